>>> src/dwc_pkg.sv
// Package for the depthwise row convolution block.
// Holds field widths, action and register codes, controller state, command/status structs.
// No dependencies; every other file but dwc_ram imports it.
package dwc_pkg;

    // Default sizes handed to the top-level parameters
    localparam int MAX_TAPS_DEF = 16;
    localparam int CHANNELS_DEF = 64;

    // Field widths
    localparam int TAP_W     = 5;    // kernel_taps register, tap counters, fill level
    localparam int STRIDE_W  = 5;
    localparam int PAD_W     = 4;
    localparam int PHASE_W   = 4;
    localparam int POS_W     = 12;
    localparam int CHAN_W    = 6;
    localparam int SAMPLE_W  = 16;
    localparam int VALUE_W   = 32;
    localparam int ACC_W     = 38;
    localparam int STEP_W    = 4;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // Action codes of an input item
    localparam logic [1:0] ACT_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_BIAS   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    // Register indexes (word address)
    localparam logic [1:0] REG_KERNEL_TAPS = 2'd0;
    localparam logic [1:0] REG_STRIDE      = 2'd1;
    localparam logic [1:0] REG_PAD_COUNT   = 2'd2;

    // Register reset values
    localparam logic [TAP_W-1:0]    KERNEL_TAPS_RST = 5'd3;
    localparam logic [STRIDE_W-1:0] STRIDE_RST      = 5'd1;
    localparam logic [PAD_W-1:0]    PAD_COUNT_RST   = 4'd0;

    // Stride clamp
    localparam logic [STRIDE_W-1:0] STRIDE_MAX = 5'd16;

    // Results kept per item before the last slot is reused
    localparam logic [STEP_W-1:0] STEP_KEEP = 4'd15;

    // Saturation bounds of the accumulator
    localparam logic signed [ACC_W-1:0] ACC_MAX = 38'sd2147483647;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -38'sd2147483648;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LEAD,
        S_TRAIL,
        S_MAC,
        S_DRAIN1,
        S_DRAIN2,
        S_EMIT,
        S_CLOSE,
        S_FLUSH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic             accept;       // input item taken this cycle
        logic             push;         // shift one position into the window
        logic             push_sample;  // push the latched sample rather than a zero
        logic             load_trail;   // reload pad counter for trailing zeros
        logic             mac_issue;    // read one tap
        logic             mac_first;    // first tap: seed accumulator with bias
        logic [TAP_W-1:0] mac_tap;
        logic             emit;         // close a window sum, release held output
        logic             close;        // final result of the row
        logic             flush;        // move the overflow slot to the output
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic             emit_now;     // a push now completes a window
        logic             pad_zero;
        logic             last_sample;
        logic [TAP_W-1:0] taps;         // effective kernel taps
        logic             pend_valid;
        logic             to_hold;      // next result goes to the overflow slot
        logic             out_free;
        logic             hold_valid;
    } status_t;

    // One result item
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [CHAN_W-1:0]         chan;
        logic [POS_W-1:0]          pos;
        logic                      last;
        logic                      sat;
        logic                      err;
    } res_t;

    // Clamp a 32-bit word to Q1.15
    function automatic logic signed [SAMPLE_W-1:0] clamp16(input logic signed [VALUE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 32'sd32767)
            r = 16'sh7fff;
        else if (v < -32'sd32768)
            r = 16'sh8000;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

>>> src/dwc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

>>> src/dwc_regs.sv
// Configuration registers behind the APB-style port: kernel_taps, stride, pad_count.
// Depends on dwc_pkg.
module dwc_regs
    import dwc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    output logic [TAP_W-1:0]    kernel_taps,
    output logic [STRIDE_W-1:0] stride,
    output logic [PAD_W-1:0]    pad_count
);

    logic [TAP_W-1:0]    kernel_taps_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [PAD_W-1:0]    pad_count_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_taps_reg <= KERNEL_TAPS_RST;
            stride_reg      <= STRIDE_RST;
            pad_count_reg   <= PAD_COUNT_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_KERNEL_TAPS: kernel_taps_reg <= pwdata[TAP_W-1:0];
                REG_STRIDE:      stride_reg      <= pwdata[STRIDE_W-1:0];
                REG_PAD_COUNT:   pad_count_reg   <= pwdata[PAD_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (paddr[3:2])
            REG_KERNEL_TAPS: prdata = APB_DW'(kernel_taps_reg);
            REG_STRIDE:      prdata = APB_DW'(stride_reg);
            REG_PAD_COUNT:   prdata = APB_DW'(pad_count_reg);
            default:         prdata = '0;
        endcase
    end

    assign kernel_taps = kernel_taps_reg;
    assign stride      = stride_reg;
    assign pad_count   = pad_count_reg;

endmodule

>>> src/dwc_ctrl.sv
// Controller state machine: sequences padding, window pushes, the tap MAC loop and
// result release for each input item. Depends on dwc_pkg.
module dwc_ctrl
    import dwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] action,
    output logic       in_stall,
    input  status_t    status,
    output cmd_t       cmd
);

    ctrl_state_t      state_reg, state_next;
    ctrl_state_t      ret_reg, ret_next;
    ctrl_state_t      push_ret;
    logic [TAP_W-1:0] tap_reg, tap_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            tap_reg   <= tap_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        cmd         = '0;
        cmd.mac_tap = tap_reg;
        state_next  = state_reg;
        ret_next    = ret_reg;
        tap_next    = tap_reg;
        push_ret    = S_IDLE;
        in_stall    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (action == ACT_SAMPLE)
                        state_next = S_LEAD;
                end
            end
            // leading zeros, then the sample itself
            S_LEAD:
            begin
                cmd.push = 1'b1;
                tap_next = '0;
                if (status.pad_zero)
                begin
                    cmd.push_sample = 1'b1;
                    if (status.last_sample)
                    begin
                        cmd.load_trail = 1'b1;
                        push_ret       = S_TRAIL;
                    end
                    else
                        push_ret = S_FLUSH;
                end
                else
                    push_ret = S_LEAD;
                ret_next   = push_ret;
                state_next = status.emit_now ? S_MAC : push_ret;
            end
            // trailing zeros after the last sample of a row
            S_TRAIL:
            begin
                tap_next = '0;
                if (status.pad_zero)
                    state_next = S_CLOSE;
                else
                begin
                    cmd.push   = 1'b1;
                    ret_next   = S_TRAIL;
                    state_next = status.emit_now ? S_MAC : S_TRAIL;
                end
            end
            // one tap per cycle
            S_MAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_first = (tap_reg == '0);
                if (tap_reg == status.taps - TAP_W'(1))
                    state_next = S_DRAIN1;
                else
                    tap_next = tap_reg + TAP_W'(1);
            end
            S_DRAIN1: state_next = S_DRAIN2;
            S_DRAIN2: state_next = S_EMIT;
            S_EMIT:
            begin
                if (!(status.pend_valid && !status.to_hold && !status.out_free))
                begin
                    cmd.emit   = 1'b1;
                    state_next = ret_reg;
                end
            end
            S_CLOSE:
            begin
                if (status.to_hold || status.out_free)
                begin
                    cmd.close  = 1'b1;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!status.hold_valid)
                    state_next = S_IDLE;
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> src/dwc_datapath.sv
// Datapath: weight and bias RAMs, sample window, tap multiplier and accumulator,
// row counters, held output, overflow slot and output register.
// Depends on dwc_pkg and dwc_ram.
module dwc_datapath
    import dwc_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic [1:0]                 action,
    input  logic [CHAN_W-1:0]          channel,
    input  logic [3:0]                 tap,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic                       last_in_row,
    input  logic [TAP_W-1:0]           kernel_taps,
    input  logic [STRIDE_W-1:0]        stride,
    input  logic [PAD_W-1:0]           pad_count,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic signed [VALUE_W-1:0]  result_value,
    output logic [CHAN_W-1:0]          out_channel,
    output logic [POS_W-1:0]           out_position,
    output logic                       last_of_row,
    output logic                       saturated,
    output logic                       row_too_short
);

    localparam int WIN_AW  = MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1;
    localparam int W_DEPTH = CHANNELS * MAX_TAPS;
    localparam int W_AW    = W_DEPTH > 1 ? $clog2(W_DEPTH) : 1;
    localparam int B_AW    = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

    // Effective register values
    logic [TAP_W-1:0]    k_eff;
    logic [STRIDE_W-1:0] stride_eff;

    always_comb
    begin
        if (kernel_taps == '0)
            k_eff = TAP_W'(1);
        else if (int'(kernel_taps) > MAX_TAPS)
            k_eff = TAP_W'(MAX_TAPS);
        else
            k_eff = kernel_taps;
        if (stride == '0)
            stride_eff = STRIDE_W'(1);
        else if (stride > STRIDE_MAX)
            stride_eff = STRIDE_MAX;
        else
            stride_eff = stride;
    end

    // Row state
    logic                       row_active_reg;
    logic [CHAN_W-1:0]          row_channel_reg;
    logic [TAP_W-1:0]           fill_reg, fill_next, fill_inc;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [PHASE_W:0]           phase_inc;
    logic [POS_W-1:0]           count_reg;
    logic [PAD_W-1:0]           pad_left_reg;
    logic                       last_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] win_reg [MAX_TAPS];
    logic                       start_row, accept_sample, emit_now;

    assign accept_sample = cmd.accept && (action == ACT_SAMPLE);
    assign start_row     = accept_sample && !row_active_reg;

    // Window fill and stride phase after one push
    assign fill_inc  = fill_reg + TAP_W'(1);
    assign phase_inc = {1'b0, phase_reg} + (PHASE_W+1)'(1);

    always_comb
    begin
        fill_next  = fill_reg;
        phase_next = phase_reg;
        emit_now   = 1'b0;
        if (fill_reg < k_eff)
        begin
            fill_next = fill_inc;
            if (fill_inc == k_eff)
            begin
                phase_next = '0;
                emit_now   = 1'b1;
            end
        end
        else if (phase_inc >= stride_eff)
        begin
            phase_next = '0;
            emit_now   = 1'b1;
        end
        else
            phase_next = phase_inc[PHASE_W-1:0];
    end

    // Sample window: newest at index 0
    always_ff @(posedge clk)
    begin
        if (start_row)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
                win_reg[i] <= '0;
        end
        else if (cmd.push)
        begin
            for (int i = MAX_TAPS - 1; i > 0; i--)
                win_reg[i] <= win_reg[i-1];
            win_reg[0] <= cmd.push_sample ? sample_reg : '0;
        end
    end

    // Latched sample
    always_ff @(posedge clk)
    begin
        if (accept_sample)
            sample_reg <= clamp16(value);
    end

    // Weight and bias stores
    logic [31:0]         w_waddr_wide, w_raddr_wide, ch_in_wide, ch_row_wide;
    logic                ch_in_ok, ch_row_ok;
    logic                w_we, b_we;
    logic [SAMPLE_W-1:0] w_rdata;
    logic [VALUE_W-1:0]  b_rdata;

    assign ch_in_wide   = 32'(channel);
    assign ch_row_wide  = 32'(row_channel_reg);
    assign ch_in_ok     = int'(channel) < CHANNELS;
    assign ch_row_ok    = int'(row_channel_reg) < CHANNELS;
    assign w_waddr_wide = ch_in_wide * 32'(MAX_TAPS) + 32'(tap);
    assign w_raddr_wide = ch_row_wide * 32'(MAX_TAPS) + 32'(cmd.mac_tap);
    assign w_we = cmd.accept && (action == ACT_WEIGHT) && ch_in_ok && (int'(tap) < MAX_TAPS);
    assign b_we = cmd.accept && (action == ACT_BIAS) && ch_in_ok;

    dwc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (W_DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr_wide[W_AW-1:0]),
        .wdata (clamp16(value)),
        .raddr (w_raddr_wide[W_AW-1:0]),
        .rdata (w_rdata)
    );

    dwc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CHANNELS)
    ) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (ch_in_wide[B_AW-1:0]),
        .wdata (value),
        .raddr (ch_row_wide[B_AW-1:0]),
        .rdata (b_rdata)
    );

    // MAC pipeline: read, multiply, accumulate
    logic                       iss_d1_reg, first_d1_reg, prod_valid_reg;
    logic [TAP_W-1:0]           tap_d1_reg;
    logic signed [VALUE_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] w_op, s_op;
    logic [31:0]                win_idx_wide;

    assign win_idx_wide = 32'(k_eff) - 32'd1 - 32'(tap_d1_reg);
    assign w_op = ch_row_ok ? signed'(w_rdata) : '0;
    assign s_op = win_reg[win_idx_wide[WIN_AW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_d1_reg     <= 1'b0;
            first_d1_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            tap_d1_reg     <= '0;
        end
        else
        begin
            iss_d1_reg     <= cmd.mac_issue;
            first_d1_reg   <= cmd.mac_first;
            prod_valid_reg <= iss_d1_reg;
            tap_d1_reg     <= cmd.mac_tap;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= w_op * s_op;
        if (iss_d1_reg && first_d1_reg)
            acc_reg <= ch_row_ok ? ACC_W'(signed'(b_rdata)) : '0;
        else if (prod_valid_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // Saturation of the finished sum
    logic                      sat_hi, sat_lo;
    logic signed [VALUE_W-1:0] sum_sat;

    assign sat_hi  = acc_reg > ACC_MAX;
    assign sat_lo  = acc_reg < ACC_MIN;
    assign sum_sat = sat_hi ? ACC_MAX[VALUE_W-1:0] :
                     sat_lo ? ACC_MIN[VALUE_W-1:0] : acc_reg[VALUE_W-1:0];

    // Held output and result routing
    logic                      pend_valid_reg, pend_sat_reg;
    logic signed [VALUE_W-1:0] pend_value_reg;
    logic [POS_W-1:0]          pend_pos_reg;
    logic [STEP_W-1:0]         step_cnt_reg;
    logic                      hold_valid_reg, out_valid_reg;
    res_t                      hold_reg, out_reg, app_data;
    logic                      app_req, to_hold, out_free, out_load;

    assign app_req  = (cmd.emit && pend_valid_reg) || cmd.close;
    assign to_hold  = step_cnt_reg == STEP_KEEP;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (app_req && !to_hold) || cmd.flush;

    always_comb
    begin
        app_data.chan = row_channel_reg;
        app_data.last = cmd.close;
        if (cmd.close && !pend_valid_reg)
        begin
            // row that gave no window at all
            app_data.value = '0;
            app_data.pos   = '0;
            app_data.sat   = 1'b0;
            app_data.err   = 1'b1;
        end
        else
        begin
            app_data.value = pend_value_reg;
            app_data.pos   = pend_pos_reg;
            app_data.sat   = pend_sat_reg;
            app_data.err   = 1'b0;
        end
    end

    // Row control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_active_reg  <= 1'b0;
            row_channel_reg <= '0;
            fill_reg        <= '0;
            phase_reg       <= '0;
            count_reg       <= '0;
            pad_left_reg    <= '0;
            last_reg        <= 1'b0;
            pend_valid_reg  <= 1'b0;
            step_cnt_reg    <= '0;
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // item start
            if (accept_sample)
            begin
                last_reg       <= last_in_row;
                step_cnt_reg   <= '0;
                hold_valid_reg <= 1'b0;
                pad_left_reg   <= row_active_reg ? '0 : pad_count;
            end
            if (start_row)
            begin
                row_active_reg  <= 1'b1;
                row_channel_reg <= channel;
                fill_reg        <= '0;
                phase_reg       <= '0;
                count_reg       <= '0;
                pend_valid_reg  <= 1'b0;
            end
            // window push
            if (cmd.push)
            begin
                fill_reg  <= fill_next;
                phase_reg <= phase_next;
                if (!cmd.push_sample)
                    pad_left_reg <= pad_left_reg - PAD_W'(1);
            end
            if (cmd.load_trail)
                pad_left_reg <= pad_count;
            // new window sum replaces the held output
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
                count_reg      <= count_reg + POS_W'(1);
            end
            if (cmd.close)
            begin
                pend_valid_reg <= 1'b0;
                row_active_reg <= 1'b0;
            end
            // result routing
            if (app_req)
            begin
                if (to_hold)
                    hold_valid_reg <= 1'b1;
                else
                    step_cnt_reg <= step_cnt_reg + STEP_W'(1);
            end
            if (cmd.flush)
                hold_valid_reg <= 1'b0;
            // output register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_value_reg <= sum_sat;
            pend_sat_reg   <= sat_hi || sat_lo;
            pend_pos_reg   <= count_reg;
        end
        if (app_req && to_hold)
            hold_reg <= app_data;
        if (cmd.flush)
            out_reg <= hold_reg;
        else if (app_req && !to_hold)
            out_reg <= app_data;
    end

    // Status to the controller
    assign status.emit_now    = emit_now;
    assign status.pad_zero    = pad_left_reg == '0;
    assign status.last_sample = last_reg;
    assign status.taps        = k_eff;
    assign status.pend_valid  = pend_valid_reg;
    assign status.to_hold     = to_hold;
    assign status.out_free    = out_free;
    assign status.hold_valid  = hold_valid_reg;

    // Output ports
    assign out_valid     = out_valid_reg;
    assign result_value  = out_reg.value;
    assign out_channel   = out_reg.chan;
    assign out_position  = out_reg.pos;
    assign last_of_row   = out_reg.last;
    assign saturated     = out_reg.sat;
    assign row_too_short = out_reg.err;

endmodule

>>> src/depthwise_row_convolution.sv
// Depthwise 1-D row convolution, top level.
// Input channel (in_valid/in_stall) takes one item at a time: a weight load, a bias
// load or a sample of a channel row. Weights are Q1.15, biases and results Q2.30.
// Output channel (out_valid/out_stall) delivers results from an output register;
// each result is held until the next window completes, so the last one of a row
// can carry last_of_row. A row with no complete window gives one row_too_short item.
// A load or an idle action is taken in the idle state. A sample makes its window
// pushes (pad_count leading zeros on the first sample of a row, then the sample);
// the pushes of the last sample of a row also include pad_count trailing zeros.
// Every push that completes a window runs the taps one per cycle through a single
// multiplier with registered weight reads. A stalled receiver holds the block when
// a result is ready and the output register is still full.
// Configuration goes through the APB-style port (kernel_taps at 0x0, stride at 0x4,
// pad_count at 0x8); the user must write it only while the block is idle, which the
// block itself does not enforce. Reset clears the registers to 3, 1, 0, ends any row
// and empties the output; weight and bias stores hold no reset value.
// Depends on dwc_pkg, dwc_regs, dwc_ctrl, dwc_datapath and dwc_ram.
module depthwise_row_convolution
    import dwc_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    // input items
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic [CHAN_W-1:0]         channel,
    input  logic [3:0]                tap,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last_in_row,
    // result items
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] result_value,
    output logic [CHAN_W-1:0]         out_channel,
    output logic [POS_W-1:0]          out_position,
    output logic                      last_of_row,
    output logic                      saturated,
    output logic                      row_too_short
);

    logic [TAP_W-1:0]    kernel_taps;
    logic [STRIDE_W-1:0] stride;
    logic [PAD_W-1:0]    pad_count;
    cmd_t                cmd;
    status_t             status;

    dwc_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .kernel_taps (kernel_taps),
        .stride      (stride),
        .pad_count   (pad_count)
    );

    dwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dwc_datapath #(
        .MAX_TAPS (MAX_TAPS),
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .action        (action),
        .channel       (channel),
        .tap           (tap),
        .value         (value),
        .last_in_row   (last_in_row),
        .kernel_taps   (kernel_taps),
        .stride        (stride),
        .pad_count     (pad_count),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .result_value  (result_value),
        .out_channel   (out_channel),
        .out_position  (out_position),
        .last_of_row   (last_of_row),
        .saturated     (saturated),
        .row_too_short (row_too_short)
    );

endmodule
